// ----- hw/rtl/tth_pkg.sv -----
package tth_pkg;

  localparam int EDGE_W      = 17;
  localparam int VEC_W       = 32;
  localparam int UNIT_W      = 16;
  localparam int UNIT_ONE    = 16384;
  localparam int SQ_STEPS    = 31;
  localparam int DIV_STEPS   = 16;
  localparam int UNIT_LAT    = 4 + SQ_STEPS + DIV_STEPS + 1;
  localparam int TOTAL_LAT   = 2 * UNIT_LAT + 8;
  localparam int ADDR_W      = 3;

  localparam logic [15:0] LIMIT_RESET = 16'd268;
  localparam logic [0:0]  REG_DEGENERATE_LIMIT = 1'b0;

  typedef struct packed {
    logic [47:0] corner_a_pos;
    logic [47:0] corner_b_pos;
    logic [47:0] corner_c_pos;
    logic [31:0] corner_a_uv;
    logic [31:0] corner_b_uv;
    logic [31:0] corner_c_uv;
    logic [47:0] face_normal;
  } tri_item_t;

  typedef struct packed {
    logic [47:0] tangent_xyz;
    logic        mirrored;
    logic        degenerate;
  } res_item_t;

endpackage

// ----- hw/rtl/tth_unitize.sv -----
module tth_unitize import tth_pkg::*; #(
  parameter int IN_W = EDGE_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [2:0][IN_W-1:0]         vec,
  output logic                         out_valid,
  output logic [2:0][UNIT_W-1:0]       unit
);

  localparam int K_W = $clog2(IN_W - 14);

  // stage a: magnitudes
  logic                  a_valid;
  logic [2:0]            a_neg;
  logic [2:0][IN_W-1:0]  a_mag;
  logic [2:0][IN_W-1:0]  mag_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][IN_W-1] ? (~vec[i] + 1'b1) : vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      a_neg[i] <= vec[i][IN_W-1];
    end
    a_mag <= mag_in;
  end

  // stage b: scale down to 16 bits
  logic                  b_valid;
  logic [2:0]            b_neg;
  logic [2:0][15:0]      b_a;
  logic [IN_W-1:0]       mx;
  logic [K_W-1:0]        k;

  always_comb begin
    mx = a_mag[0];
    if (a_mag[1] > mx) mx = a_mag[1];
    if (a_mag[2] > mx) mx = a_mag[2];
    k = '0;
    for (int bi = 16; bi < IN_W; bi++) begin
      if (mx[bi]) k = K_W'(bi - 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_neg <= a_neg;
    for (int i = 0; i < 3; i++) begin
      b_a[i] <= 16'(a_mag[i] >> k);
    end
  end

  // stage c: squares
  logic                  c_valid;
  logic [2:0]            c_neg;
  logic [2:0][15:0]      c_a;
  logic [2:0][31:0]      c_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_neg <= b_neg;
    c_a   <= b_a;
    for (int i = 0; i < 3; i++) begin
      c_sq[i] <= 32'(b_a[i]) * 32'(b_a[i]);
    end
  end

  // stage d: sum of squares, then square root one bit per stage
  logic [33:0] m2;
  assign m2 = 34'(c_sq[0]) + 34'(c_sq[1]) + 34'(c_sq[2]);

  logic                  sq_valid [SQ_STEPS+1];
  logic [2:0]            sq_neg   [SQ_STEPS+1];
  logic                  sq_zero  [SQ_STEPS+1];
  logic [2:0][15:0]      sq_a     [SQ_STEPS+1];
  logic [63:0]           sq_rem   [SQ_STEPS+1];
  logic [30:0]           sq_root  [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= c_valid;
    end
    sq_neg[0]  <= c_neg;
    sq_zero[0] <= (m2 == '0);
    sq_a[0]    <= c_a;
    sq_rem[0]  <= {2'b00, m2, 28'd0};
    sq_root[0] <= '0;
  end

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    localparam int J = SQ_STEPS - 1 - s;
    logic [63:0] trial;
    logic        take;

    always_comb begin
      trial = (({33'd0, sq_root[s]} << 1) | (64'd1 << J)) << J;
      take  = (sq_rem[s] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[s+1] <= 1'b0;
      end else begin
        sq_valid[s+1] <= sq_valid[s];
      end
      sq_neg[s+1]  <= sq_neg[s];
      sq_zero[s+1] <= sq_zero[s];
      sq_a[s+1]    <= sq_a[s];
      sq_rem[s+1]  <= take ? (sq_rem[s] - trial) : sq_rem[s];
      sq_root[s+1] <= take ? (sq_root[s] | (31'd1 << J)) : sq_root[s];
    end
  end

  // division of each scaled component by the root, one quotient bit per stage
  logic                  dv_valid [DIV_STEPS+1];
  logic [2:0]            dv_neg   [DIV_STEPS+1];
  logic                  dv_zero  [DIV_STEPS+1];
  logic [30:0]           dv_s     [DIV_STEPS+1];
  logic [2:0][47:0]      dv_rem   [DIV_STEPS+1];
  logic [2:0][15:0]      dv_q     [DIV_STEPS+1];

  assign dv_valid[0] = sq_valid[SQ_STEPS];
  assign dv_neg[0]   = sq_neg[SQ_STEPS];
  assign dv_zero[0]  = sq_zero[SQ_STEPS];
  assign dv_s[0]     = sq_root[SQ_STEPS];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = {4'd0, sq_a[SQ_STEPS][i], 28'd0};
      dv_q[0][i]   = '0;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int I = DIV_STEPS - 1 - s;
    logic [47:0] dsh;
    logic [2:0]  ge;

    always_comb begin
      dsh = {17'd0, dv_s[s]} << I;
      for (int i = 0; i < 3; i++) begin
        ge[i] = (dv_rem[s][i] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else begin
        dv_valid[s+1] <= dv_valid[s];
      end
      dv_neg[s+1]  <= dv_neg[s];
      dv_zero[s+1] <= dv_zero[s];
      dv_s[s+1]    <= dv_s[s];
      for (int i = 0; i < 3; i++) begin
        dv_rem[s+1][i] <= ge[i] ? (dv_rem[s][i] - dsh) : dv_rem[s][i];
        dv_q[s+1][i]   <= ge[i] ? (dv_q[s][i] | (16'd1 << I)) : dv_q[s][i];
      end
    end
  end

  // cap, sign, zero vector
  logic [2:0][15:0] capped;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      capped[i] = (dv_q[DIV_STEPS][i] > 16'(UNIT_ONE)) ? 16'(UNIT_ONE) : dv_q[DIV_STEPS][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[DIV_STEPS];
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[DIV_STEPS]) begin
        unit[i] <= '0;
      end else if (dv_neg[DIV_STEPS][i]) begin
        unit[i] <= UNIT_W'(-capped[i]);
      end else begin
        unit[i] <= UNIT_W'(capped[i]);
      end
    end
  end

endmodule

// ----- hw/rtl/triangle_tangent_handedness.sv -----
// throughput: one item per cycle, busy is only high during reset
// two normalize passes of 52 stages each (31-step square root, 16-step divide) set the latency
// reset clears all valid bits and sets degenerate_limit to 268
// results leave on done for one cycle, the receiver cannot stall
module triangle_tangent_handedness import tth_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tri_item_t         triangle,
  output logic              done,
  output res_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int N_DLY = 2 * UNIT_LAT + 4;

  // configuration
  logic [15:0] degenerate_limit;

  assign pready = 1'b1;
  assign busy   = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEGENERATE_LIMIT) begin
      degenerate_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_DEGENERATE_LIMIT) begin
      prdata = {16'd0, degenerate_limit};
    end else begin
      prdata = '0;
    end
  end

  // edges
  logic                   t1_valid;
  logic [2:0][EDGE_W-1:0] e1v, e2v, uv1v, uv2v;
  logic [47:0]            n_dly [N_DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      e1v[i] <= {triangle.corner_b_pos[16*i+15], triangle.corner_b_pos[16*i +: 16]}
              - {triangle.corner_a_pos[16*i+15], triangle.corner_a_pos[16*i +: 16]};
      e2v[i] <= {triangle.corner_c_pos[16*i+15], triangle.corner_c_pos[16*i +: 16]}
              - {triangle.corner_a_pos[16*i+15], triangle.corner_a_pos[16*i +: 16]};
    end
    for (int i = 0; i < 2; i++) begin
      uv1v[i] <= {triangle.corner_b_uv[16*i+15], triangle.corner_b_uv[16*i +: 16]}
               - {triangle.corner_a_uv[16*i+15], triangle.corner_a_uv[16*i +: 16]};
      uv2v[i] <= {triangle.corner_c_uv[16*i+15], triangle.corner_c_uv[16*i +: 16]}
               - {triangle.corner_a_uv[16*i+15], triangle.corner_a_uv[16*i +: 16]};
    end
    uv1v[2] <= '0;
    uv2v[2] <= '0;
    n_dly[0] <= triangle.face_normal;
    for (int d = 1; d < N_DLY; d++) begin
      n_dly[d] <= n_dly[d-1];
    end
  end

  // first normalize pass
  logic [3:0]             u1_valid;
  logic [2:0][UNIT_W-1:0] e1u, e2u, t1u, t2u;

  tth_unitize #(.IN_W(EDGE_W)) u_norm_e1 (
    .clk(clk), .rst(rst), .in_valid(t1_valid), .vec(e1v),
    .out_valid(u1_valid[0]), .unit(e1u)
  );
  tth_unitize #(.IN_W(EDGE_W)) u_norm_e2 (
    .clk(clk), .rst(rst), .in_valid(t1_valid), .vec(e2v),
    .out_valid(u1_valid[1]), .unit(e2u)
  );
  tth_unitize #(.IN_W(EDGE_W)) u_norm_uv1 (
    .clk(clk), .rst(rst), .in_valid(t1_valid), .vec(uv1v),
    .out_valid(u1_valid[2]), .unit(t1u)
  );
  tth_unitize #(.IN_W(EDGE_W)) u_norm_uv2 (
    .clk(clk), .rst(rst), .in_valid(t1_valid), .vec(uv2v),
    .out_valid(u1_valid[3]), .unit(t2u)
  );

  // determinant and raw tangent / bitangent products
  logic                     d1_valid;
  logic signed [31:0]       p_det0, p_det1;
  logic signed [2:0][31:0]  pt_a, pt_b, pb_a, pb_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else begin
      d1_valid <= &u1_valid;
    end
    p_det0 <= $signed(t1u[0]) * $signed(t2u[1]);
    p_det1 <= $signed(t1u[1]) * $signed(t2u[0]);
    for (int i = 0; i < 3; i++) begin
      pt_a[i] <= $signed(t2u[1]) * $signed(e1u[i]);
      pt_b[i] <= $signed(t1u[1]) * $signed(e2u[i]);
      pb_a[i] <= $signed(t1u[0]) * $signed(e2u[i]);
      pb_b[i] <= $signed(t2u[0]) * $signed(e1u[i]);
    end
  end

  logic                    d2_valid;
  logic [31:0]             det;
  logic [2:0][31:0]        vt, vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid <= 1'b0;
    end else begin
      d2_valid <= d1_valid;
    end
    det <= p_det0 - p_det1;
    for (int i = 0; i < 3; i++) begin
      vt[i] <= pt_a[i] - pt_b[i];
      vb[i] <= pb_a[i] - pb_b[i];
    end
  end

  logic                    d3_valid;
  logic [2:0][VEC_W-1:0]   vt_s, vb_s;
  logic [31:0]             dmag;
  logic                    deg_dly [UNIT_LAT+1];

  assign dmag = det[31] ? (~det + 1'b1) : det;

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_valid <= 1'b0;
    end else begin
      d3_valid <= d2_valid;
    end
    deg_dly[0] <= (dmag < {16'd0, degenerate_limit});
    for (int i = 0; i < 3; i++) begin
      vt_s[i] <= det[31] ? VEC_W'(-vt[i]) : VEC_W'(vt[i]);
      vb_s[i] <= det[31] ? VEC_W'(-vb[i]) : VEC_W'(vb[i]);
    end
    for (int d = 1; d <= UNIT_LAT; d++) begin
      deg_dly[d] <= deg_dly[d-1];
    end
  end

  // second normalize pass
  logic [1:0]             u2_valid;
  logic [2:0][UNIT_W-1:0] tu, bu;

  tth_unitize #(.IN_W(VEC_W)) u_norm_t (
    .clk(clk), .rst(rst), .in_valid(d3_valid), .vec(vt_s),
    .out_valid(u2_valid[0]), .unit(tu)
  );
  tth_unitize #(.IN_W(VEC_W)) u_norm_b (
    .clk(clk), .rst(rst), .in_valid(d3_valid), .vec(vb_s),
    .out_valid(u2_valid[1]), .unit(bu)
  );

  // handedness
  logic [2:0][UNIT_W-1:0] tsel, bsel;
  logic [47:0]            nrm;

  assign nrm = n_dly[N_DLY-1];

  always_comb begin
    if (deg_dly[UNIT_LAT]) begin
      tsel = {16'd0, 16'd0, 16'(UNIT_ONE)};
      bsel = {16'd0, 16'(UNIT_ONE), 16'd0};
    end else begin
      tsel = tu;
      bsel = bu;
    end
  end

  logic                    c1_valid, c1_deg;
  logic [2:0][UNIT_W-1:0]  c1_t, c1_b;
  logic signed [5:0][31:0] c1_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else begin
      c1_valid <= &u2_valid;
    end
    c1_deg <= deg_dly[UNIT_LAT];
    c1_t   <= tsel;
    c1_b   <= bsel;
    c1_p[0] <= $signed(nrm[31:16]) * $signed(tsel[2]);
    c1_p[1] <= $signed(nrm[47:32]) * $signed(tsel[1]);
    c1_p[2] <= $signed(nrm[47:32]) * $signed(tsel[0]);
    c1_p[3] <= $signed(nrm[15:0])  * $signed(tsel[2]);
    c1_p[4] <= $signed(nrm[15:0])  * $signed(tsel[1]);
    c1_p[5] <= $signed(nrm[31:16]) * $signed(tsel[0]);
  end

  logic                    c2_valid, c2_deg;
  logic [2:0][UNIT_W-1:0]  c2_t, c2_b;
  logic signed [2:0][31:0] cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else begin
      c2_valid <= c1_valid;
    end
    c2_deg <= c1_deg;
    c2_t   <= c1_t;
    c2_b   <= c1_b;
    cr[0]  <= c1_p[0] - c1_p[1];
    cr[1]  <= c1_p[2] - c1_p[3];
    cr[2]  <= c1_p[4] - c1_p[5];
  end

  logic                    c3_valid, c3_deg;
  logic [2:0][UNIT_W-1:0]  c3_t;
  logic signed [2:0][47:0] dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_valid <= 1'b0;
    end else begin
      c3_valid <= c2_valid;
    end
    c3_deg <= c2_deg;
    c3_t   <= c2_t;
    for (int i = 0; i < 3; i++) begin
      dp[i] <= $signed(cr[i]) * $signed(c2_b[i]);
    end
  end

  logic signed [49:0] dot;

  assign dot = 50'($signed(dp[0])) + 50'($signed(dp[1])) + 50'($signed(dp[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c3_valid;
    end
    result.tangent_xyz <= {c3_t[2], c3_t[1], c3_t[0]};
    result.mirrored    <= dot[49];
    result.degenerate  <= c3_deg;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without matching item");

  a_degen_tangent: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |-> result.tangent_xyz == {32'd0, 16'(UNIT_ONE)})
    else $error("degenerate item with wrong tangent");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(result.tangent_xyz[15:0]) <= 16'sd16384
           && $signed(result.tangent_xyz[15:0]) >= -16'sd16384
           && $signed(result.tangent_xyz[31:16]) <= 16'sd16384
           && $signed(result.tangent_xyz[31:16]) >= -16'sd16384
           && $signed(result.tangent_xyz[47:32]) <= 16'sd16384
           && $signed(result.tangent_xyz[47:32]) >= -16'sd16384))
    else $error("tangent component out of unit range");

endmodule

// ----- dv/tb_triangle_tangent_handedness.sv -----
`timescale 1ns / 1ps

module tb_triangle_tangent_handedness;
  import tth_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  tri_item_t         triangle;
  logic              done;
  res_item_t         result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  typedef struct {
    tri_item_t tri_in;
    logic      has_want;
    res_item_t want;
  } stim_row_t;

  res_item_t   tangent_queue[$];
  logic [15:0] limit_model;
  int          error_count;
  int          send_idle_pct;

  triangle_tangent_handedness dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .triangle(triangle),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [49:0] got,
                                 input logic [49:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic longint sx16(input logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic make_unit(input longint c[3], output longint o[3]);
    longint unsigned a[3];
    longint unsigned mx;
    longint unsigned m2;
    longint unsigned s;
    longint unsigned q;
    mx = 0;
    m2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? -c[i] : c[i];
      if (a[i] > mx) mx = a[i];
    end
    while (mx >= 65536) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) m2 += a[i] * a[i];
    if (m2 == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
    end else begin
      s = root64(m2 << 28);
      for (int i = 0; i < 3; i++) begin
        q = (a[i] << 28) / s;
        if (q > 16384) q = 16384;
        o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endtask

  task automatic predict_tangent(input tri_item_t tr, output res_item_t r);
    longint pa[3], pb[3], pc[3], nv[3], v[3];
    longint e1[3], e2[3], te1[3], te2[3], t[3], b[3], cr[3];
    longint det, dmag, dotp;
    logic degen;
    for (int i = 0; i < 3; i++) begin
      pa[i] = sx16(tr.corner_a_pos[16*i +: 16]);
      pb[i] = sx16(tr.corner_b_pos[16*i +: 16]);
      pc[i] = sx16(tr.corner_c_pos[16*i +: 16]);
      nv[i] = sx16(tr.face_normal[16*i +: 16]);
    end
    for (int i = 0; i < 3; i++) v[i] = pb[i] - pa[i];
    make_unit(v, e1);
    for (int i = 0; i < 3; i++) v[i] = pc[i] - pa[i];
    make_unit(v, e2);
    v[0] = sx16(tr.corner_b_uv[15:0]) - sx16(tr.corner_a_uv[15:0]);
    v[1] = sx16(tr.corner_b_uv[31:16]) - sx16(tr.corner_a_uv[31:16]);
    v[2] = 0;
    make_unit(v, te1);
    v[0] = sx16(tr.corner_c_uv[15:0]) - sx16(tr.corner_a_uv[15:0]);
    v[1] = sx16(tr.corner_c_uv[31:16]) - sx16(tr.corner_a_uv[31:16]);
    v[2] = 0;
    make_unit(v, te2);
    det = te1[0] * te2[1] - te1[1] * te2[0];
    dmag = det < 0 ? -det : det;
    degen = dmag < longint'(limit_model);
    if (degen) begin
      t = '{16384, 0, 0};
      b = '{0, 16384, 0};
    end else begin
      for (int i = 0; i < 3; i++) begin
        v[i] = te2[1] * e1[i] - te1[1] * e2[i];
        if (det < 0) v[i] = -v[i];
      end
      make_unit(v, t);
      for (int i = 0; i < 3; i++) begin
        v[i] = te1[0] * e2[i] - te2[0] * e1[i];
        if (det < 0) v[i] = -v[i];
      end
      make_unit(v, b);
    end
    cr[0] = nv[1] * t[2] - nv[2] * t[1];
    cr[1] = nv[2] * t[0] - nv[0] * t[2];
    cr[2] = nv[0] * t[1] - nv[1] * t[0];
    dotp = cr[0] * b[0] + cr[1] * b[1] + cr[2] * b[2];
    for (int i = 0; i < 3; i++) r.tangent_xyz[16*i +: 16] = t[i][15:0];
    r.mirrored = dotp < 0;
    r.degenerate = degen;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (tangent_queue.size() == 0) begin
        report_mismatch("unexpected item", 50'(result), '0);
      end else begin
        res_item_t w;
        w = tangent_queue.pop_front();
        if (result.tangent_xyz !== w.tangent_xyz)
          report_mismatch("tangent_xyz", 50'(result.tangent_xyz), 50'(w.tangent_xyz));
        if (result.mirrored !== w.mirrored)
          report_mismatch("mirrored", 50'(result.mirrored), 50'(w.mirrored));
        if (result.degenerate !== w.degenerate)
          report_mismatch("degenerate", 50'(result.degenerate), 50'(w.degenerate));
      end
    end
  end

  task automatic write_limit(input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_DEGENERATE_LIMIT);
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_model = val;
  endtask

  task automatic send_triangle(input tri_item_t tr, input logic has_want,
                               input res_item_t want);
    res_item_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    predict_tangent(tr, r);
    if (has_want) begin
      if (r !== want) report_mismatch("table row", r, want);
      r = want;
    end
    start <= 1'b1;
    triangle <= tr;
    @(posedge clk);
    while (busy) @(posedge clk);
    tangent_queue = {tangent_queue, r};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tangent_queue.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(1023)) - 16'd512;
      default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic tri_item_t rand_triangle();
    tri_item_t tr;
    int mode;
    int pick;
    mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(4) == 0 ? 2 : 0);
    for (int i = 0; i < 3; i++) begin
      tr.corner_a_pos[16*i +: 16] = rand_coord(mode);
      tr.corner_b_pos[16*i +: 16] = rand_coord(mode);
      tr.corner_c_pos[16*i +: 16] = rand_coord(mode);
      tr.face_normal[16*i +: 16] = $urandom_range(3) == 0 ? 16'($urandom)
                                   : 16'($urandom_range(32768)) - 16'd16384;
    end
    for (int i = 0; i < 2; i++) begin
      tr.corner_a_uv[16*i +: 16] = rand_coord(mode);
      tr.corner_b_uv[16*i +: 16] = rand_coord(mode);
      tr.corner_c_uv[16*i +: 16] = rand_coord(mode);
    end
    pick = $urandom_range(19);
    // coincident corners or collinear texture coordinates
    if (pick == 0) tr.corner_b_pos = tr.corner_a_pos;
    if (pick == 1) tr.corner_c_uv = tr.corner_b_uv;
    if (pick == 2) tr.corner_b_uv = tr.corner_a_uv;
    return tr;
  endfunction

  stim_row_t directed[$];

  initial begin
    stim_row_t row;
    logic [15:0] limits[4];
    rst = 1'b1;
    start = 1'b0;
    triangle = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    send_idle_pct = 0;
    limit_model = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all zero: zero edges, degenerate defaults
    row.tri_in = '0;
    row.has_want = 1'b1;
    row.want = '{tangent_xyz: {16'd0, 16'd0, 16'd16384}, mirrored: 1'b0,
                 degenerate: 1'b1};
    directed = {directed, row};
    // right triangle in xy with legs of 0x100, uv aligned
    row.tri_in = '0;
    row.tri_in.corner_b_pos = {16'd0, 16'd0, 16'h0100};
    row.tri_in.corner_c_pos = {16'd0, 16'h0100, 16'd0};
    row.tri_in.corner_b_uv = {16'd0, 16'h1000};
    row.tri_in.corner_c_uv = {16'h1000, 16'd0};
    row.tri_in.face_normal = {16'd16384, 16'd0, 16'd0};
    row.want = '{tangent_xyz: {16'd0, 16'd0, 16'd16384}, mirrored: 1'b0,
                 degenerate: 1'b0};
    directed = {directed, row};
    // mirrored uv
    row.tri_in.corner_c_uv = {16'hf000, 16'd0};
    row.want.mirrored = 1'b1;
    directed = {directed, row};
    row.has_want = 1'b0;
    row.tri_in.corner_a_pos = {3{16'h8000}};
    row.tri_in.corner_b_pos = {3{16'h7fff}};
    row.tri_in.corner_c_pos = {16'h8000, 16'h7fff, 16'h8000};
    row.tri_in.corner_a_uv = {2{16'h8000}};
    row.tri_in.corner_b_uv = {16'h8000, 16'h7fff};
    row.tri_in.corner_c_uv = {2{16'h7fff}};
    row.tri_in.face_normal = {3{16'hffff}};
    directed = {directed, row};
    row.tri_in.corner_a_pos = {3{16'h7fff}};
    row.tri_in.corner_b_pos = {3{16'h8000}};
    row.tri_in.face_normal = {3{16'h8000}};
    directed = {directed, row};
    for (int k = 0; k < 15; k++) begin
      row.tri_in = rand_triangle();
      directed = {directed, row};
    end

    foreach (directed[k]) send_triangle(directed[k].tri_in, directed[k].has_want,
                                        directed[k].want);
    drain();

    limits = '{16'd0, 16'hffff, 16'd5000, LIMIT_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      send_idle_pct = ph == 0 ? 19 : (ph == 1 ? 87 : 0);
      for (int k = 0; k < (ph == 1 ? 150 : 230); k++)
        send_triangle(rand_triangle(), 1'b0, row.want);
      drain();
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tth_pkg.sv
hw/rtl/tth_unitize.sv
hw/rtl/triangle_tangent_handedness.sv
dv/tb_triangle_tangent_handedness.sv
